// ----- hw/rtl/gpb_pkg.sv -----
package gpb_pkg;

  localparam int GROUP_COUNT_DEF    = 2;
  localparam int PINS_PER_GROUP_DEF = 32;
  localparam int WORD_W             = 32;
  localparam int BYTE_W             = 8;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [3:0] {
    REG_IN     = 4'd0,
    REG_OUT    = 4'd1,
    REG_OUTSET = 4'd2,
    REG_OUTCLR = 4'd3,
    REG_OUTTGL = 4'd4,
    REG_DIRSET = 4'd5,
    REG_DIRCLR = 4'd6,
    REG_DIR    = 4'd7,
    REG_MUX    = 4'd8,
    REG_PINCFG = 4'd9
  } gpb_reg_e;

  typedef struct packed {
    logic              req_type;
    logic              group_sel;
    logic [3:0]        reg_sel;
    logic [4:0]        byte_index;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] write_mask;
    logic [WORD_W-1:0] pin_levels;
  } gpb_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              access_error;
    logic [WORD_W-1:0] pad_output;
    logic [WORD_W-1:0] pad_direction;
    logic [WORD_W-1:0] periph_enable;
  } gpb_rsp_t;

  typedef struct packed {
    logic              mux_we;
    logic              cfg_we;
    logic [BYTE_W-1:0] wdata;
  } gpb_ram_wr_t;

endpackage

// ----- hw/rtl/gpb_chan_if.sv -----
interface gpb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gpb_byte_ram.sv -----
module gpb_byte_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [gpb_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [gpb_pkg::BYTE_W-1:0] rdata
);

  logic [gpb_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid_r;
  logic [gpb_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Entries never written read as zero, which matches the reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // A write in the same cycle is forwarded so the next word sees it.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else if (valid_r[raddr]) begin
        rdata_r <= mem[raddr];
      end else begin
        rdata_r <= '0;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/gpb_access_unit.sv -----
module gpb_access_unit #(
  parameter int GROUP_COUNT    = gpb_pkg::GROUP_COUNT_DEF,
  parameter int PINS_PER_GROUP = gpb_pkg::PINS_PER_GROUP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  gpb_pkg::gpb_req_t           req,
  input  logic [gpb_pkg::BYTE_W-1:0]  mux_byte,
  input  logic [gpb_pkg::BYTE_W-1:0]  cfg_byte,
  output gpb_pkg::gpb_rsp_t           rsp,
  output gpb_pkg::gpb_ram_wr_t        wr
);

  localparam int P         = PINS_PER_GROUP;
  localparam int GW        = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int PW        = $clog2(PINS_PER_GROUP);
  localparam int MUX_SLOTS = (PINS_PER_GROUP + 1) / 2;

  logic [P-1:0] latch_r [GROUP_COUNT];
  logic [P-1:0] dir_r   [GROUP_COUNT];
  logic [P-1:0] en_r    [GROUP_COUNT];

  logic                       g_ok;
  logic [GW-1:0]              g;
  logic                       is_wr;
  logic [P-1:0]               m;
  logic [P-1:0]               d;
  logic [P-1:0]               cur_latch;
  logic [P-1:0]               cur_dir;
  logic [P-1:0]               cur_en;
  logic [P-1:0]               latch_n;
  logic [P-1:0]               dir_n;
  logic [P-1:0]               en_n;
  logic [gpb_pkg::WORD_W-1:0] rd;
  logic                       err;
  logic                       mux_we;
  logic                       cfg_we;

  assign g_ok      = int'(req.group_sel) < GROUP_COUNT;
  assign g         = g_ok ? GW'(req.group_sel) : '0;
  assign is_wr     = (req.req_type == gpb_pkg::REQ_WRITE);
  assign m         = req.write_mask[P-1:0];
  assign d         = req.write_data[P-1:0];
  assign cur_latch = latch_r[g];
  assign cur_dir   = dir_r[g];
  assign cur_en    = en_r[g];

  always_comb begin
    latch_n = cur_latch;
    dir_n   = cur_dir;
    en_n    = cur_en;
    rd      = '0;
    err     = 1'b0;
    mux_we  = 1'b0;
    cfg_we  = 1'b0;
    if (!g_ok) begin
      err = 1'b1;
    end else begin
      unique case (req.reg_sel)
        gpb_pkg::REG_IN: begin
          if (is_wr) err = 1'b1;
          else rd = gpb_pkg::WORD_W'(req.pin_levels[P-1:0]);
        end
        gpb_pkg::REG_OUT: begin
          if (is_wr) latch_n = (cur_latch & ~m) | (d & m);
          else rd = gpb_pkg::WORD_W'(cur_latch);
        end
        gpb_pkg::REG_OUTSET: begin
          if (is_wr) latch_n = cur_latch | m;
          else rd = gpb_pkg::WORD_W'(cur_latch);
        end
        gpb_pkg::REG_OUTCLR: begin
          if (is_wr) latch_n = cur_latch & ~m;
          else rd = gpb_pkg::WORD_W'(cur_latch);
        end
        gpb_pkg::REG_OUTTGL: begin
          if (is_wr) latch_n = cur_latch ^ m;
          else rd = gpb_pkg::WORD_W'(cur_latch);
        end
        gpb_pkg::REG_DIRSET: begin
          if (is_wr) dir_n = cur_dir | m;
          else rd = gpb_pkg::WORD_W'(cur_dir);
        end
        gpb_pkg::REG_DIRCLR: begin
          if (is_wr) dir_n = cur_dir & ~m;
          else rd = gpb_pkg::WORD_W'(cur_dir);
        end
        gpb_pkg::REG_DIR: begin
          if (is_wr) dir_n = (cur_dir & ~m) | (d & m);
          else rd = gpb_pkg::WORD_W'(cur_dir);
        end
        gpb_pkg::REG_MUX: begin
          if (int'(req.byte_index) >= MUX_SLOTS) err = 1'b1;
          else if (is_wr) mux_we = 1'b1;
          else rd = gpb_pkg::WORD_W'(mux_byte);
        end
        gpb_pkg::REG_PINCFG: begin
          if (int'(req.byte_index) >= P) begin
            err = 1'b1;
          end else if (is_wr) begin
            cfg_we = 1'b1;
            en_n[req.byte_index[PW-1:0]] = req.write_data[0];
          end else begin
            rd = gpb_pkg::WORD_W'(cfg_byte);
          end
        end
        default: err = 1'b1;
      endcase
    end
    if (is_wr || err) rd = '0;
  end

  always_comb begin
    rsp.read_data     = rd;
    rsp.access_error  = err;
    rsp.pad_output    = g_ok ? gpb_pkg::WORD_W'(latch_n) : '0;
    rsp.pad_direction = g_ok ? gpb_pkg::WORD_W'(dir_n) : '0;
    rsp.periph_enable = g_ok ? gpb_pkg::WORD_W'(en_n) : '0;
    wr.mux_we         = fire && mux_we;
    wr.cfg_we         = fire && cfg_we;
    wr.wdata          = req.write_data[gpb_pkg::BYTE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GROUP_COUNT; i++) begin
        latch_r[i] <= '0;
        dir_r[i]   <= '0;
        en_r[i]    <= '0;
      end
    end else if (fire && g_ok) begin
      latch_r[g] <= latch_n;
      dir_r[g]   <= dir_n;
      en_r[g]    <= en_n;
    end
  end

endmodule

// ----- hw/rtl/gpio_port_register_bank.sv -----
// GPIO port register bank with set, clear and toggle registers.
//
// in_chan carries one access word per handshake (read or write, group,
// register code, byte index, write data, write mask and sampled pad
// levels). out_chan returns exactly one word per access: read data, an
// error flag, and the group's output latch, direction and peripheral
// enables as they stand after the access.
//
// An access is registered in the input register on acceptance, worked
// out from there and held in an output register, from which its result
// is offered until the receiver takes it.
// One word is accepted every cycle while the output is not stalled; the
// rate is set by the registered read port of the mux and pin config byte
// memories, whose reads are forwarded from a write in the same cycle.
//
// Reset clears the latches, the directions and the valid bits of both byte
// memories, so every pin is an input and every byte reads zero. No
// clearing pass is needed. While the receiver stalls, the result is held
// and one more word can wait in the input register before in_chan.ready
// drops.
module gpio_port_register_bank #(
  parameter int GROUP_COUNT    = gpb_pkg::GROUP_COUNT_DEF,
  parameter int PINS_PER_GROUP = gpb_pkg::PINS_PER_GROUP_DEF
) (
  input logic        clk,
  input logic        rst_n,
  gpb_chan_if.sink   in_chan,
  gpb_chan_if.source out_chan
);

  localparam int MUX_SLOTS = (PINS_PER_GROUP + 1) / 2;
  localparam int MUX_DEPTH = GROUP_COUNT * MUX_SLOTS;
  localparam int MUX_AW    = (MUX_DEPTH > 1) ? $clog2(MUX_DEPTH) : 1;
  localparam int CFG_DEPTH = GROUP_COUNT * PINS_PER_GROUP;
  localparam int CFG_AW    = (CFG_DEPTH > 1) ? $clog2(CFG_DEPTH) : 1;

  logic                 in_fire;
  logic                 s1_fire;
  logic                 s1_valid_r;
  gpb_pkg::gpb_req_t    s1_req_r;
  logic [MUX_AW-1:0]    s1_mux_addr_r;
  logic [CFG_AW-1:0]    s1_cfg_addr_r;
  logic [MUX_AW-1:0]    acc_mux_addr;
  logic [CFG_AW-1:0]    acc_cfg_addr;
  logic                 out_valid_r;
  gpb_pkg::gpb_rsp_t    out_data_r;
  gpb_pkg::gpb_rsp_t    rsp;
  gpb_pkg::gpb_ram_wr_t ram_wr;
  logic [gpb_pkg::BYTE_W-1:0] mux_byte;
  logic [gpb_pkg::BYTE_W-1:0] cfg_byte;

  assign s1_fire       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Flat byte addresses: group times slots per group plus the index.
  assign acc_mux_addr = MUX_AW'(int'(in_chan.data.group_sel) * MUX_SLOTS
                                + int'(in_chan.data.byte_index));
  assign acc_cfg_addr = CFG_AW'(int'(in_chan.data.group_sel) * PINS_PER_GROUP
                                + int'(in_chan.data.byte_index));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r      <= in_chan.data;
      s1_mux_addr_r <= acc_mux_addr;
      s1_cfg_addr_r <= acc_cfg_addr;
    end
  end

  gpb_byte_ram #(
    .DEPTH (MUX_DEPTH),
    .AW    (MUX_AW)
  ) u_mux_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_wr.mux_we),
    .waddr (s1_mux_addr_r),
    .wdata (ram_wr.wdata),
    .re    (in_fire),
    .raddr (acc_mux_addr),
    .rdata (mux_byte)
  );

  gpb_byte_ram #(
    .DEPTH (CFG_DEPTH),
    .AW    (CFG_AW)
  ) u_cfg_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_wr.cfg_we),
    .waddr (s1_cfg_addr_r),
    .wdata (ram_wr.wdata),
    .re    (in_fire),
    .raddr (acc_cfg_addr),
    .rdata (cfg_byte)
  );

  gpb_access_unit #(
    .GROUP_COUNT    (GROUP_COUNT),
    .PINS_PER_GROUP (PINS_PER_GROUP)
  ) u_access (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .req      (s1_req_r),
    .mux_byte (mux_byte),
    .cfg_byte (cfg_byte),
    .rsp      (rsp),
    .wr       (ram_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= rsp;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("accepted access did not reach the output register");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_chan.ready)
    else $error("input not ready while the input register is empty");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.access_error) |-> (out_data_r.read_data == '0))
    else $error("errored access returned nonzero read data");

  a_unused_pins_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.pad_output >> PINS_PER_GROUP) == '0))
    else $error("latch bit above the group width is set");

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MUX_SLOTS    = (gpb_pkg::PINS_PER_GROUP_DEF + 1) / 2;
  localparam int MUX_IW       = $clog2(MUX_SLOTS);
  localparam int GROUPS       = gpb_pkg::GROUP_COUNT_DEF;
  localparam int PINS         = gpb_pkg::PINS_PER_GROUP_DEF;
  localparam int WW           = gpb_pkg::WORD_W;
  localparam int BW           = gpb_pkg::BYTE_W;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 250;
  localparam int RANDOM_WORDS = 1725;

  localparam logic       RD         = gpb_pkg::REQ_READ;
  localparam logic       WR         = gpb_pkg::REQ_WRITE;
  localparam logic [3:0] UNKNOWN_LO = 4'd10;
  localparam logic [3:0] UNKNOWN_HI = 4'd15;

  typedef struct {
    gpb_pkg::gpb_req_t word;
    bit                drain_first;
  } queued_access_t;

  logic clk = 1'b0;
  logic rst_n;

  gpb_chan_if #(.T(gpb_pkg::gpb_req_t)) req_if ();
  gpb_chan_if #(.T(gpb_pkg::gpb_rsp_t)) rsp_if ();

  gpio_port_register_bank DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  // Shadow copy of the port state, updated in acceptance order.
  logic [WW-1:0] shadow_latch [GROUPS];
  logic [WW-1:0] shadow_dir   [GROUPS];
  logic [BW-1:0] shadow_mux   [GROUPS][MUX_SLOTS];
  logic [BW-1:0] shadow_pcfg  [GROUPS][PINS];

  queued_access_t    queued_accesses[$];
  queued_access_t    next_access;
  gpb_pkg::gpb_rsp_t awaited_responses[$];
  gpb_pkg::gpb_rsp_t want;

  int total_words;
  int accepted_words;
  int seen_responses;
  int mismatches;
  int hold_cycles;
  bit long_hold_done;
  int cycle_count;

  always #5 clk = ~clk;

  function automatic bit calm_stretch(int n);
    return n >= 900 && n < 1200;
  endfunction

  function automatic logic [WW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Works out the response of one access and applies its effect on the shadow state.
  function automatic gpb_pkg::gpb_rsp_t apply_access(gpb_pkg::gpb_req_t a);
    gpb_pkg::gpb_rsp_t r;
    int g;
    bit wr;
    r = '0;
    g = int'(a.group_sel);
    wr = (a.req_type == gpb_pkg::REQ_WRITE);
    case (a.reg_sel)
      gpb_pkg::REG_IN: begin
        if (wr) r.access_error = 1'b1;
        else r.read_data = a.pin_levels;
      end
      gpb_pkg::REG_OUT, gpb_pkg::REG_OUTSET, gpb_pkg::REG_OUTCLR, gpb_pkg::REG_OUTTGL: begin
        if (!wr) r.read_data = shadow_latch[g];
        else if (a.reg_sel == gpb_pkg::REG_OUT)
          shadow_latch[g] = (shadow_latch[g] & ~a.write_mask) |
                            (a.write_data & a.write_mask);
        else if (a.reg_sel == gpb_pkg::REG_OUTSET)
          shadow_latch[g] = shadow_latch[g] | a.write_mask;
        else if (a.reg_sel == gpb_pkg::REG_OUTCLR)
          shadow_latch[g] = shadow_latch[g] & ~a.write_mask;
        else shadow_latch[g] = shadow_latch[g] ^ a.write_mask;
      end
      gpb_pkg::REG_DIRSET, gpb_pkg::REG_DIRCLR, gpb_pkg::REG_DIR: begin
        if (!wr) r.read_data = shadow_dir[g];
        else if (a.reg_sel == gpb_pkg::REG_DIRSET)
          shadow_dir[g] = shadow_dir[g] | a.write_mask;
        else if (a.reg_sel == gpb_pkg::REG_DIRCLR)
          shadow_dir[g] = shadow_dir[g] & ~a.write_mask;
        else shadow_dir[g] = (shadow_dir[g] & ~a.write_mask) | (a.write_data & a.write_mask);
      end
      gpb_pkg::REG_MUX: begin
        if (a.byte_index >= MUX_SLOTS) r.access_error = 1'b1;
        else if (wr) shadow_mux[g][a.byte_index[MUX_IW-1:0]] = a.write_data[BW-1:0];
        else r.read_data = {24'd0, shadow_mux[g][a.byte_index[MUX_IW-1:0]]};
      end
      gpb_pkg::REG_PINCFG: begin
        if (a.byte_index >= PINS) r.access_error = 1'b1;
        else if (wr) shadow_pcfg[g][a.byte_index] = a.write_data[BW-1:0];
        else r.read_data = {24'd0, shadow_pcfg[g][a.byte_index]};
      end
      default: r.access_error = 1'b1;
    endcase
    if (wr || r.access_error) r.read_data = '0;
    r.pad_output = shadow_latch[g];
    r.pad_direction = shadow_dir[g];
    for (int i = 0; i < PINS; i++) r.periph_enable[i] = shadow_pcfg[g][i][0];
    return r;
  endfunction

  task automatic add_access(input logic wr, input logic grp, input logic [3:0] code,
                            input logic [4:0] idx, input logic [WW-1:0] data,
                            input logic [WW-1:0] mask, input logic [WW-1:0] levels,
                            input bit drain_first);
    queued_access_t q;
    q.word.req_type = wr;
    q.word.group_sel = grp;
    q.word.reg_sel = code;
    q.word.byte_index = idx;
    q.word.write_data = data;
    q.word.write_mask = mask;
    q.word.pin_levels = levels;
    q.drain_first = drain_first;
    queued_accesses.push_back(q);
  endtask

  // Sender: offers the next queued word once the current one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        shadow_latch[g] = '0;
        shadow_dir[g] = '0;
        for (int i = 0; i < MUX_SLOTS; i++) shadow_mux[g][i] = '0;
        for (int i = 0; i < PINS; i++) shadow_pcfg[g][i] = '0;
      end
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_responses.push_back(apply_access(req_if.data));
        accepted_words++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (queued_accesses.size() != 0 &&
            !(queued_accesses[0].drain_first && awaited_responses.size() != 0) &&
            (calm_stretch(accepted_words) || $urandom_range(99) >= 10)) begin
          next_access = queued_accesses.pop_front();
          req_if.valid <= 1'b1;
          req_if.data <= next_access.word;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each response against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen_responses++;
        if (awaited_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("response with no access outstanding: %p", rsp_if.data);
        end else begin
          want = awaited_responses.pop_front();
          if (rsp_if.data.read_data !== want.read_data ||
              rsp_if.data.access_error !== want.access_error ||
              rsp_if.data.pad_output !== want.pad_output ||
              rsp_if.data.pad_direction !== want.pad_direction ||
              rsp_if.data.periph_enable !== want.periph_enable) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("response %0d: exp rd=%h err=%b out=%h dir=%h en=%h",
                       seen_responses, want.read_data, want.access_error, want.pad_output,
                       want.pad_direction, want.periph_enable);
              $display("response %0d: got rd=%h err=%b out=%h dir=%h en=%h",
                       seen_responses, rsp_if.data.read_data, rsp_if.data.access_error,
                       rsp_if.data.pad_output, rsp_if.data.pad_direction,
                       rsp_if.data.periph_enable);
            end
          end
        end
        // One long hold-off so the block fills up and stalls its input.
        if (seen_responses == 300 && !long_hold_done) begin
          hold_cycles = LONG_HOLD;
          long_hold_done = 1'b1;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= calm_stretch(seen_responses) || $urandom_range(99) >= 10;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [3:0] code;
    logic [4:0] idx;
    rst_n = 1'b0;

    add_access(RD, 1'b0, gpb_pkg::REG_IN,     5'd0,  '0, '0, '1, 0);
    add_access(WR, 1'b0, gpb_pkg::REG_OUT,    5'd0,  '1, '1, '0, 0);
    add_access(WR, 1'b1, gpb_pkg::REG_OUT,    5'd3,  32'hA5A5A5A5, 32'h0000FFFF, '1, 0);
    add_access(WR, 1'b0, gpb_pkg::REG_OUTCLR, 5'd0,  '1, 32'h0F0F0F0F, '0, 0);
    add_access(WR, 1'b1, gpb_pkg::REG_OUTSET, 5'd0,  '0, 32'h80000001, '0, 0);
    add_access(WR, 1'b0, gpb_pkg::REG_OUTTGL, 5'd0,  '0, '1, '0, 0);
    add_access(RD, 1'b0, gpb_pkg::REG_OUTSET, 5'd0,  '1, '1, '0, 0);
    add_access(RD, 1'b1, gpb_pkg::REG_OUTCLR, 5'd0,  '0, '0, '0, 0);
    add_access(RD, 1'b0, gpb_pkg::REG_OUTTGL, 5'd0,  '0, '0, '0, 0);
    add_access(RD, 1'b1, gpb_pkg::REG_OUT,    5'd0,  '0, '0, '0, 0);
    add_access(WR, 1'b0, gpb_pkg::REG_DIRSET, 5'd0,  '0, '1, '0, 0);
    add_access(WR, 1'b0, gpb_pkg::REG_DIRCLR, 5'd0,  '1, 32'h0000FFFF, '0, 0);
    add_access(WR, 1'b1, gpb_pkg::REG_DIR,    5'd0,  32'h12345678, 32'hF0F0F0F0, '0, 0);
    add_access(RD, 1'b1, gpb_pkg::REG_DIRSET, 5'd0,  '0, '0, '0, 0);
    add_access(RD, 1'b0, gpb_pkg::REG_DIRCLR, 5'd0,  '0, '0, '0, 0);
    add_access(RD, 1'b0, gpb_pkg::REG_DIR,    5'd0,  '0, '0, '0, 0);
    add_access(WR, 1'b0, gpb_pkg::REG_MUX,    5'd0,  '1, '0, '0, 0);
    add_access(WR, 1'b1, gpb_pkg::REG_MUX,    5'd15, 32'h0000005A, '0, '0, 0);
    add_access(WR, 1'b0, gpb_pkg::REG_MUX,    5'd16, '1, '1, '0, 0);
    add_access(RD, 1'b1, gpb_pkg::REG_MUX,    5'd15, '0, '0, '0, 0);
    add_access(WR, 1'b0, gpb_pkg::REG_PINCFG, 5'd31, 32'h00000001, '0, '0, 0);
    add_access(WR, 1'b1, gpb_pkg::REG_PINCFG, 5'd0,  '1, '0, '0, 0);
    add_access(RD, 1'b0, gpb_pkg::REG_PINCFG, 5'd31, '0, '0, '0, 0);
    add_access(WR, 1'b1, gpb_pkg::REG_IN,     5'd0,  '1, '1, '1, 0);
    add_access(RD, 1'b1, UNKNOWN_LO,          5'd31, '1, '1, '1, 0);
    add_access(WR, 1'b0, UNKNOWN_HI,          5'd0,  '1, '1, '1, 0);

    // Random part: mostly valid register codes, a few unknown ones and
    // out-of-range mux indexes. Some words wait until the port has drained.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(99) < 8) code = 4'($urandom_range(UNKNOWN_HI, UNKNOWN_LO));
      else code = 4'($urandom_range(gpb_pkg::REG_PINCFG, gpb_pkg::REG_IN));
      if (code == gpb_pkg::REG_MUX && $urandom_range(99) < 85)
        idx = 5'($urandom_range(MUX_SLOTS - 1));
      else idx = 5'($urandom_range(31));
      add_access(1'($urandom_range(1)), 1'($urandom_range(1)), code, idx,
                 pick_word(), pick_word(), pick_word(),
                 n == 0 || n == 500 || n == 1400);
    end
    total_words = queued_accesses.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_words < total_words || awaited_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/gpb_pkg.sv
hw/rtl/gpb_chan_if.sv
hw/rtl/gpb_byte_ram.sv
hw/rtl/gpb_access_unit.sv
hw/rtl/gpio_port_register_bank.sv
tb/tb.sv
